// File: rtl/slrr_pkg.sv
// Shared types and constants for the shuffled Lehmer range generator.
// Holds the generator constants, the step request struct and the controller
// state encoding; depends on nothing else.
package slrr_pkg;

    localparam int WORD_W      = 31;
    localparam int TABLE_DEPTH = 32;
    localparam int INDEX_W     = 5;

    localparam logic [14:0] MULT    = 15'd16807;
    localparam logic [16:0] QUOT    = 17'd127773;
    localparam logic [11:0] REMF    = 12'd2836;
    localparam logic [30:0] MODULUS = 31'h7FFF_FFFF;

    // floor(2^48 / QUOT): the quotient estimate is exact or one low
    localparam int          RECIP_SHIFT = 48;
    localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(QUOT));

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic {
        MODE_SEED = 1'b0,
        MODE_DRAW = 1'b1
    } step_mode_t;

    typedef struct packed {
        logic       start;
        step_mode_t mode;
    } step_req_t;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEED_RD  = 5'b00010,
        ST_SEED     = 5'b00100,
        ST_DRAW_RD  = 5'b01000,
        ST_DRAW_RUN = 5'b10000
    } state_t;

endpackage

// File: rtl/shuffled_lehmer_range_random.sv
// Top level of the shuffled Lehmer range generator: controller, shuffle table
// memory and output register. Depends on slrr_pkg, slrr_step and slrr_mod.
//
// Usage:
//   A transaction is taken on the rising edge where start is high and busy is
//   low; command, seed_value, lower_bound and upper_bound are sampled there.
//   A reseed transaction (command 0) returns nothing. It clamps the seed to at
//   least 1 and runs WARMUP_STEPS generator steps, filling table entries 31
//   down to 1; busy stays high while the four-stage generator step runs once
//   per warm-up step.
//   A draw transaction (command 1) returns one result: strobe is high for a
//   single cycle with value and fell_back. It waits for the generator step and for
//   the one-bit-per-cycle remainder unit; when lower_bound exceeds upper_bound
//   the remainder is skipped, value is lower_bound, fell_back is 1, and the
//   result waits only for the generator step.
//   The generator step, table swap and remainder overlap within a draw.
//   The receiver cannot stall: each result is shown once and must be taken.
//   Reset clears the table (through per-entry valid bits), the shuffle word
//   and the generator word at once; no clearing pass is needed.
module shuffled_lehmer_range_random #(
    parameter int WARMUP_STEPS = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic signed [31:0] seed_value,
    input  logic signed [30:0] lower_bound,
    input  logic signed [30:0] upper_bound,
    output logic               strobe,
    output logic signed [30:0] value,
    output logic               fell_back
);
    import slrr_pkg::*;

    localparam int CNT_W = $clog2(WARMUP_STEPS + 1);

    // controller registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    word_t               gen_reg, gen_next;
    word_t               shuf_reg, shuf_next;
    logic                gen_done_reg, gen_done_next;
    logic                fb_reg, fb_next;
    word_t               lo_reg, lo_next;
    word_t               hi_reg, hi_next;
    logic [INDEX_W-1:0]  slot_reg, slot_next;

    // output register
    logic                strobe_reg, strobe_next;
    word_t               value_reg, value_next;
    logic                fell_back_reg, fell_back_next;

    // shuffle table: synchronous memory plus valid bits for the reset value
    word_t                  table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    word_t                  rd_data_reg;
    logic                   rd_hit_reg;
    logic                   mem_re;
    logic [INDEX_W-1:0]     rd_addr;
    logic                   mem_we;
    logic [INDEX_W-1:0]     wr_addr;
    word_t                  mem_word;

    // generator step and remainder unit
    step_req_t          step_req;
    word_t              step_x;
    logic               step_done;
    word_t              step_result;
    logic               mod_start;
    logic               mod_busy;
    word_t              mod_rem;
    logic [WORD_W:0]    span;
    word_t              seed_clamp;
    logic               finish;

    assign mem_word   = rd_hit_reg ? rd_data_reg : '0;
    assign seed_clamp = (seed_value[31] || seed_value == 32'sd0) ? word_t'(1)
                                                                 : seed_value[WORD_W-1:0];
    // span of the range when lower <= upper: 1 up to 2^31
    assign span = {hi_reg[WORD_W-1], hi_reg} - {lo_reg[WORD_W-1], lo_reg}
                  + {{WORD_W{1'b0}}, 1'b1};

    slrr_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (step_req),
        .x      (step_x),
        .done   (step_done),
        .result (step_result)
    );

    slrr_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mem_word),
        .divisor   (span),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gen_next       = gen_reg;
        shuf_next      = shuf_reg;
        gen_done_next  = gen_done_reg;
        fb_next        = fb_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        fell_back_next = fell_back_reg;
        mem_re         = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        wr_addr        = '0;
        step_req       = '{start: 1'b0, mode: MODE_SEED};
        step_x         = step_result;
        mod_start      = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_RESEED)
                    begin
                        // fetch entry 0 for the shuffle word, launch the first step
                        mem_re     = 1'b1;
                        rd_addr    = '0;
                        step_req   = '{start: 1'b1, mode: MODE_SEED};
                        step_x     = seed_clamp;
                        cnt_next   = CNT_W'(WARMUP_STEPS);
                        state_next = ST_SEED_RD;
                    end
                    else
                    begin
                        // read the slot picked by the shuffle word, advance generator
                        mem_re        = 1'b1;
                        rd_addr       = shuf_reg[INDEX_W-1:0];
                        slot_next     = shuf_reg[INDEX_W-1:0];
                        step_req      = '{start: 1'b1, mode: MODE_DRAW};
                        step_x        = gen_reg;
                        lo_next       = lower_bound;
                        hi_next       = upper_bound;
                        fb_next       = lower_bound > upper_bound;
                        gen_done_next = 1'b0;
                        state_next    = ST_DRAW_RD;
                    end
                end
            end

            ST_SEED_RD:
            begin
                // entry 0 is never written while seeding
                shuf_next  = mem_word;
                state_next = ST_SEED;
            end

            ST_SEED:
            begin
                if (step_done)
                begin
                    if (cnt_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        mem_we  = 1'b1;
                        wr_addr = cnt_reg[INDEX_W-1:0];
                    end
                    if (cnt_reg == CNT_W'(1))
                    begin
                        gen_next   = step_result;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        step_req = '{start: 1'b1, mode: MODE_SEED};
                        step_x   = step_result;
                    end
                end
            end

            ST_DRAW_RD:
            begin
                // old entry becomes the shuffle word and the word to reduce
                shuf_next  = mem_word;
                mod_start  = !fb_reg;
                state_next = ST_DRAW_RUN;
            end

            ST_DRAW_RUN:
            begin
                if (step_done)
                begin
                    mem_we        = 1'b1;
                    wr_addr       = slot_reg;
                    gen_next      = step_result;
                    gen_done_next = 1'b1;
                end
                if ((gen_done_reg || step_done) && !mod_busy)
                begin
                    finish         = 1'b1;
                    value_next     = fb_reg ? lo_reg : word_t'(lo_reg + mod_rem);
                    fell_back_next = fb_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        strobe_next = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            gen_reg      <= '0;
            shuf_reg     <= '0;
            gen_done_reg <= 1'b0;
            fb_reg       <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            gen_reg      <= gen_next;
            shuf_reg     <= shuf_next;
            gen_done_reg <= gen_done_next;
            fb_reg       <= fb_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        slot_reg      <= slot_next;
        value_reg     <= value_next;
        fell_back_reg <= fell_back_next;
    end

    // table storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_addr] <= step_result;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // an entry not yet written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign value     = value_reg;
    assign fell_back = fell_back_reg;

`ifndef SYNTHESIS
    a_strobe_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_DRAW_RUN))
        else $error("result strobe without a finished draw");

    a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SEED || state_reg == ST_DRAW_RUN))
        else $error("table write outside seeding or drawing");

    a_step_expected: assert property (@(posedge clk) disable iff (!rst_n)
        step_done |-> (state_reg == ST_SEED || state_reg == ST_DRAW_RUN))
        else $error("generator step finished with nobody waiting");

    a_fallback_value: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && fell_back_reg) |-> (value_reg == lo_reg))
        else $error("fallback result differs from lower bound");

    a_mod_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        mod_start |-> !mod_busy)
        else $error("remainder unit restarted while busy");
`endif

endmodule

// File: rtl/slrr_step.sv
// Four-stage pipelined Schrage step of the 16807 mod 2^31-1 generator.
// Divides by the Schrage quotient through a reciprocal multiply with one
// correction; depends on slrr_pkg.
module slrr_step (
    input  logic               clk,
    input  logic               rst_n,
    input  slrr_pkg::step_req_t req,
    input  slrr_pkg::word_t    x,
    output logic               done,
    output slrr_pkg::word_t    result
);
    import slrr_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, done_reg;
    step_mode_t  m1_reg, m2_reg, m3_reg;

    logic [62:0] prod_reg;
    word_t       x1_reg;
    logic [14:0] hi_est_reg;
    logic [17:0] lo_est_reg;
    logic [31:0] pa_reg;
    logic [26:0] pr_reg;
    word_t       result_reg;

    logic [62:0] prod_next;
    logic [14:0] hi_est;
    logic [31:0] qh;
    logic [31:0] lo_est;
    logic        lo_over;
    logic [17:0] lo_fix;
    logic [16:0] lo_val;
    logic [14:0] hi_val;
    logic [31:0] pa_next;
    logic [26:0] pr_next;
    logic [32:0] diff;
    logic [32:0] diff_fix;
    word_t       result_next;

    always_comb
    begin
        prod_next = {32'd0, x} * {31'd0, RECIP};

        hi_est = prod_reg[62:48];
        qh     = {15'd0, QUOT} * {17'd0, hi_est};
        lo_est = {1'b0, x1_reg} - qh;

        // correct a quotient estimate that came out one low
        lo_over = lo_est_reg >= {1'b0, QUOT};
        lo_fix  = lo_over ? (lo_est_reg - {1'b0, QUOT}) : lo_est_reg;
        lo_val  = lo_fix[16:0];
        hi_val  = lo_over ? 15'(hi_est_reg + 15'd1) : hi_est_reg;
        pa_next = {17'd0, MULT} * {15'd0, lo_val};
        pr_next = {15'd0, REMF} * {12'd0, hi_val};

        // seeding keeps the low 31 bits; drawing adds the modulus when negative
        diff     = {1'b0, pa_reg} - {6'd0, pr_reg};
        diff_fix = diff + {2'b00, MODULUS};
        if (m3_reg == MODE_DRAW && diff[32])
        begin
            result_next = diff_fix[WORD_W-1:0];
        end
        else
        begin
            result_next = diff[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg     <= req.mode;
        m2_reg     <= m1_reg;
        m3_reg     <= m2_reg;
        prod_reg   <= prod_next;
        x1_reg     <= x;
        hi_est_reg <= hi_est;
        lo_est_reg <= lo_est[17:0];
        pa_reg     <= pa_next;
        pr_reg     <= pr_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/slrr_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on slrr_pkg for the word width.
module slrr_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  slrr_pkg::word_t           dividend,
    input  logic [slrr_pkg::WORD_W:0] divisor,
    output logic                      busy,
    output slrr_pkg::word_t           remainder
);
    import slrr_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             quo_reg, quo_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [WORD_W:0]   div_reg, div_next;
    logic [WORD_W+1:0] sh;
    logic [WORD_W+1:0] sh_sub;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        sh        = {rem_reg, quo_reg[WORD_W-1]};
        sh_sub    = sh - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // bring in the next bit and subtract where it fits
            rem_next = (sh >= {1'b0, div_reg}) ? sh_sub[WORD_W:0] : sh[WORD_W:0];
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg[WORD_W-1:0];

endmodule
